// ===== src/ptrx_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrx_pkg
// shared widths, field offsets and codes for the persistent trie max-xor block
// ----------------------------------------------------------------------------
package ptrx_pkg;

    // defaults for the top level parameters
    localparam int KEY_BITS_DEF     = 31;
    localparam int MAX_VERSIONS_DEF = 4096;

    // fixed field widths on the stream ports
    localparam int KEY_FIELD_W    = 31;
    localparam int VER_FIELD_W    = 13;
    localparam int STATUS_W       = 2;
    localparam int BEST_FIELD_W   = 31;

    // input tdata layout, lowest bit first: key, left_version, right_version
    localparam int IN_KEY_LSB     = 0;
    localparam int IN_LEFT_LSB    = IN_KEY_LSB + KEY_FIELD_W;
    localparam int IN_RIGHT_LSB   = IN_LEFT_LSB + VER_FIELD_W;
    localparam int IN_USED_W      = IN_RIGHT_LSB + VER_FIELD_W;
    localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first: status, best_xor, version
    localparam int OUT_USED_W     = STATUS_W + BEST_FIELD_W + VER_FIELD_W;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // item kinds
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== src/ptrx_ram.sv =====
// ----------------------------------------------------------------------------
// ptrx_ram
// generic ram, one write port and two read ports, registered read data
// ----------------------------------------------------------------------------
module ptrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/persistent_trie_range_max_xor.sv =====
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor
// insert: root read, then one new node a level down to the leaf
// query: root read, then child read then count read at every level
// refused insert or bad range: straight to the result; one item at a time,
// set by the node walk through registered ram reads
// reset: the start-up state after reset writes node zero and version zero, not ready then
// ----------------------------------------------------------------------------
module persistent_trie_range_max_xor #(
    parameter int KEY_BITS     = ptrx_pkg::KEY_BITS_DEF,
    parameter int MAX_VERSIONS = ptrx_pkg::MAX_VERSIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key, left_version, right_version, zero fill
    input  logic [ptrx_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, best_xor, version, zero fill
    output logic [ptrx_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int NODE_DEPTH = MAX_VERSIONS * (KEY_BITS + 1) + 1;
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int VER_DEPTH  = MAX_VERSIONS + 1;
    localparam int VER_W      = $clog2(VER_DEPTH);
    localparam int LVL_W      = $clog2(KEY_BITS + 1);
    localparam int CMP_W      = (VER_W > ptrx_pkg::VER_FIELD_W) ? VER_W : ptrx_pkg::VER_FIELD_W;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_IROOT = 3'd2;
    localparam logic [2:0] S_ILVL  = 3'd3;
    localparam logic [2:0] S_QROOT = 3'd4;
    localparam logic [2:0] S_QCH   = 3'd5;
    localparam logic [2:0] S_QCNT  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // input fields
    logic                                 in_kind;
    logic [ptrx_pkg::KEY_FIELD_W-1:0]     in_key;
    logic [ptrx_pkg::VER_FIELD_W-1:0]     in_left;
    logic [ptrx_pkg::VER_FIELD_W-1:0]     in_right;

    assign in_kind  = s_axis_tuser;
    assign in_key   = s_axis_tdata[ptrx_pkg::IN_KEY_LSB +: ptrx_pkg::KEY_FIELD_W];
    assign in_left  = s_axis_tdata[ptrx_pkg::IN_LEFT_LSB +: ptrx_pkg::VER_FIELD_W];
    assign in_right = s_axis_tdata[ptrx_pkg::IN_RIGHT_LSB +: ptrx_pkg::VER_FIELD_W];

    // registers
    logic [2:0]                       r_state, n_state;
    logic [VER_W-1:0]                 r_vused, n_vused;
    logic [NODE_W-1:0]                r_nused, n_nused;
    logic [KEY_BITS-1:0]              r_key, n_key;
    logic [KEY_BITS-1:0]              r_best, n_best;
    logic [LVL_W-1:0]                 r_lvl, n_lvl;
    logic [NODE_W-1:0]                r_cur, n_cur;
    logic [NODE_W-1:0]                r_lo_want, n_lo_want;
    logic [NODE_W-1:0]                r_hi_want, n_hi_want;
    logic [NODE_W-1:0]                r_lo_keep, n_lo_keep;
    logic [NODE_W-1:0]                r_hi_keep, n_hi_keep;
    logic [ptrx_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [VER_W-1:0]                 r_ver, n_ver;
    logic                             r_out_valid;
    logic [ptrx_pkg::STATUS_W-1:0]    r_out_status;
    logic [ptrx_pkg::BEST_FIELD_W-1:0] r_out_best;
    logic [ptrx_pkg::VER_FIELD_W-1:0] r_out_ver;

    // ram ports
    logic                 root_we;
    logic [VER_W-1:0]     root_waddr, root_raddr_a, root_raddr_b;
    logic [NODE_W-1:0]    root_wdata, root_rdata_a, root_rdata_b;
    logic                 cp_we;
    logic [NODE_W-1:0]    cp_waddr, cp_raddr_a, cp_raddr_b;
    logic [2*NODE_W-1:0]  cp_wdata, cp_rdata_a, cp_rdata_b;
    logic                 cnt_we;
    logic [NODE_W-1:0]    cnt_waddr, cnt_raddr_a, cnt_raddr_b;
    logic [VER_W-1:0]     cnt_wdata, cnt_rdata_a, cnt_rdata_b;

    // helpers
    logic                 key_bit;
    logic                 full;
    logic                 bad_range;
    logic                 take;
    logic                 out_load;
    logic [NODE_W-1:0]    fresh;
    logic [NODE_W-1:0]    next_lo, next_hi;
    logic [NODE_W-1:0]    prev_next;

    assign key_bit = r_key[KEY_BITS-1];
    assign fresh   = r_cur + NODE_W'(1);
    assign take    = cnt_rdata_b > cnt_rdata_a;
    assign next_lo = take ? r_lo_want : r_lo_keep;
    assign next_hi = take ? r_hi_want : r_hi_keep;
    assign prev_next = key_bit ? cp_rdata_a[2*NODE_W-1:NODE_W] : cp_rdata_a[NODE_W-1:0];

    assign full = (r_vused >= VER_W'(MAX_VERSIONS))
               || ({1'b0, r_nused} + (NODE_W+1)'(KEY_BITS + 1) > (NODE_W+1)'(NODE_DEPTH - 1));

    assign bad_range = (CMP_W'(in_right) > CMP_W'(r_vused))
                    || (CMP_W'(in_left) >= CMP_W'(in_right));

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state   = r_state;
        n_vused   = r_vused;
        n_nused   = r_nused;
        n_key     = r_key;
        n_best    = r_best;
        n_lvl     = r_lvl;
        n_cur     = r_cur;
        n_lo_want = r_lo_want;
        n_hi_want = r_hi_want;
        n_lo_keep = r_lo_keep;
        n_hi_keep = r_hi_keep;
        n_status  = r_status;
        n_ver     = r_ver;

        root_we      = 1'b0;
        root_waddr   = '0;
        root_wdata   = '0;
        root_raddr_a = '0;
        root_raddr_b = '0;
        cp_we        = 1'b0;
        cp_waddr     = '0;
        cp_wdata     = '0;
        cp_raddr_a   = '0;
        cp_raddr_b   = '0;
        cnt_we       = 1'b0;
        cnt_waddr    = '0;
        cnt_wdata    = '0;
        cnt_raddr_a  = '0;
        cnt_raddr_b  = '0;

        unique case (r_state)
            S_INIT: begin
                // null node and empty version
                root_we = 1'b1;
                cp_we   = 1'b1;
                cnt_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key  = KEY_BITS'(in_key);
                    n_best = '0;
                    n_lvl  = '0;
                    n_ver  = '0;
                    if (in_kind == ptrx_pkg::KIND_INSERT) begin
                        if (full) begin
                            n_status = ptrx_pkg::ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            root_we      = 1'b1;
                            root_waddr   = r_vused + VER_W'(1);
                            root_wdata   = r_nused + NODE_W'(1);
                            root_raddr_a = r_vused;
                            n_cur        = r_nused + NODE_W'(1);
                            n_state      = S_IROOT;
                        end
                    end else begin
                        if (bad_range) begin
                            n_status = ptrx_pkg::ST_RANGE;
                            n_state  = S_FIN;
                        end else begin
                            root_raddr_a = VER_W'(in_left);
                            root_raddr_b = VER_W'(in_right);
                            n_state      = S_QROOT;
                        end
                    end
                end
            end
            S_IROOT: begin
                cp_raddr_a  = root_rdata_a;
                cnt_raddr_a = root_rdata_a;
                n_state     = S_ILVL;
            end
            S_ILVL: begin
                // new node replaces prev: one more key below it
                cnt_we    = 1'b1;
                cnt_waddr = r_cur;
                cnt_wdata = cnt_rdata_a + VER_W'(1);
                if (r_lvl == LVL_W'(KEY_BITS)) begin
                    n_nused  = r_cur;
                    n_vused  = r_vused + VER_W'(1);
                    n_ver    = r_vused + VER_W'(1);
                    n_status = ptrx_pkg::ST_OK;
                    n_state  = S_FIN;
                end else begin
                    cp_we    = 1'b1;
                    cp_waddr = r_cur;
                    // fresh child on the key side, sibling shared with prev
                    cp_wdata = key_bit ? {fresh, cp_rdata_a[NODE_W-1:0]}
                                       : {cp_rdata_a[2*NODE_W-1:NODE_W], fresh};
                    cp_raddr_a  = prev_next;
                    cnt_raddr_a = prev_next;
                    n_cur       = fresh;
                    n_key       = r_key << 1;
                    n_lvl       = r_lvl + LVL_W'(1);
                end
            end
            S_QROOT: begin
                cp_raddr_a = root_rdata_a;
                cp_raddr_b = root_rdata_b;
                n_state    = S_QCH;
            end
            S_QCH: begin
                n_lo_want   = key_bit ? cp_rdata_a[NODE_W-1:0] : cp_rdata_a[2*NODE_W-1:NODE_W];
                n_hi_want   = key_bit ? cp_rdata_b[NODE_W-1:0] : cp_rdata_b[2*NODE_W-1:NODE_W];
                n_lo_keep   = key_bit ? cp_rdata_a[2*NODE_W-1:NODE_W] : cp_rdata_a[NODE_W-1:0];
                n_hi_keep   = key_bit ? cp_rdata_b[2*NODE_W-1:NODE_W] : cp_rdata_b[NODE_W-1:0];
                cnt_raddr_a = n_lo_want;
                cnt_raddr_b = n_hi_want;
                n_state     = S_QCNT;
            end
            S_QCNT: begin
                n_best = (r_best << 1) | KEY_BITS'(take);
                n_key  = r_key << 1;
                if (r_lvl == LVL_W'(KEY_BITS - 1)) begin
                    n_status = ptrx_pkg::ST_OK;
                    n_state  = S_FIN;
                end else begin
                    cp_raddr_a = next_lo;
                    cp_raddr_b = next_hi;
                    n_lvl      = r_lvl + LVL_W'(1);
                    n_state    = S_QCH;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_vused <= '0;
            r_nused <= '0;
        end else begin
            r_state <= n_state;
            r_vused <= n_vused;
            r_nused <= n_nused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_best    <= n_best;
        r_lvl     <= n_lvl;
        r_cur     <= n_cur;
        r_lo_want <= n_lo_want;
        r_hi_want <= n_hi_want;
        r_lo_keep <= n_lo_keep;
        r_hi_keep <= n_hi_keep;
        r_status  <= n_status;
        r_ver     <= n_ver;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_best   <= ptrx_pkg::BEST_FIELD_W'(r_best);
            r_out_ver    <= ptrx_pkg::VER_FIELD_W'(r_ver);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ptrx_pkg::OUT_TDATA_W'({r_out_ver, r_out_best, r_out_status});

    ptrx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (VER_DEPTH)
    ) u_root_ram (
        .i_clk     (i_clk),
        .i_we      (root_we),
        .i_waddr   (root_waddr),
        .i_wdata   (root_wdata),
        .i_raddr_a (root_raddr_a),
        .i_raddr_b (root_raddr_b),
        .o_rdata_a (root_rdata_a),
        .o_rdata_b (root_rdata_b)
    );

    ptrx_ram #(
        .WIDTH (2 * NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_child_ram (
        .i_clk     (i_clk),
        .i_we      (cp_we),
        .i_waddr   (cp_waddr),
        .i_wdata   (cp_wdata),
        .i_raddr_a (cp_raddr_a),
        .i_raddr_b (cp_raddr_b),
        .o_rdata_a (cp_rdata_a),
        .o_rdata_b (cp_rdata_b)
    );

    ptrx_ram #(
        .WIDTH (VER_W),
        .DEPTH (NODE_DEPTH)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_waddr   (cnt_waddr),
        .i_wdata   (cnt_wdata),
        .i_raddr_a (cnt_raddr_a),
        .i_raddr_b (cnt_raddr_b),
        .o_rdata_a (cnt_rdata_a),
        .o_rdata_b (cnt_rdata_b)
    );

    // every finished version owns exactly KEY_BITS+1 nodes
    a_pool_tracks_versions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_nused == NODE_W'(r_vused * (KEY_BITS + 1))))
        else $error("node pool out of step with version count");

    // the leaf step of an insert commits exactly one version
    a_insert_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ILVL && r_lvl == LVL_W'(KEY_BITS)) |=> (r_vused == $past(r_vused) + VER_W'(1)))
        else $error("insert did not commit one version");

    // the null node is only written by the start-up pass
    a_null_node_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cp_we || cnt_we) && r_state != S_INIT) |-> (cp_waddr != '0 && cnt_waddr != '0 || !cp_we && cnt_waddr != '0))
        else $error("write to the null node");

    // a query never walks past the last key bit
    a_query_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QCNT || r_state == S_QCH) |-> (r_lvl < LVL_W'(KEY_BITS)))
        else $error("query level out of range");

    // a result is only loaded when the output side can hold it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_state == S_FIN) |=> (r_state == S_FIN))
        else $error("result overwritten before it was taken");

endmodule
